// File: rtl/fpa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared widths, codes and controller/datapath types of the Fenwick tree unit.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int MAX_ENTRIES_DEF = 1024;
  localparam int IDX_W           = 11;
  // Walk positions need one bit more than an index: an upward step can pass 2047.
  localparam int POS_W           = IDX_W + 1;
  localparam int DATA_W          = 32;
  localparam int IN_TDATA_W      = 56;
  localparam int OUT_TDATA_W     = 32;

  localparam logic [IDX_W-1:0] SIZE_RESET = 11'd1024;

  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_SUM = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_HI,
    ST_LO_LOAD,
    ST_LO,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic step;
    logic lo_load;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic step_ok;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

// File: rtl/fpa_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_ram
// Generic RAM with one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/fpa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_ctrl
// Sequencer of the Fenwick tree unit: clearing pass, add walk, two prefix walks.
// ----------------------------------------------------------------------------
module fpa_ctrl
  import fpa_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  input  wire logic    in_tuser,
  input  wire status_t sts,
  output logic         in_tready,
  output cmd_t         cmd
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) state_nxt = (in_tuser == REQ_SUM) ? ST_HI : ST_ADD;
      end
      ST_ADD: begin
        if (!sts.step_ok) state_nxt = ST_IDLE;
      end
      ST_HI: begin
        if (!sts.step_ok) state_nxt = ST_LO_LOAD;
      end
      ST_LO_LOAD: begin
        state_nxt = ST_LO;
      end
      ST_LO: begin
        if (!sts.step_ok) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_ADD, ST_HI, ST_LO: begin
        cmd.step = 1'b1;
      end
      ST_LO_LOAD: begin
        cmd.lo_load = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = !sts.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/fpa_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_dpath
// Datapath of the Fenwick tree unit: walk position, tree memory, accumulators
// and the result register.
// ----------------------------------------------------------------------------
module fpa_dpath
  import fpa_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cmd_t                   cmd,
  output status_t                     sts,
  input  wire logic                   in_tuser,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                   cfg_valid,
  input  wire logic [IDX_W-1:0]       cfg_data,
  input  wire logic                   out_tready,
  output logic                        out_tvalid,
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  localparam int AW     = $clog2(MAX_ENTRIES);
  localparam int CAP_W  = $clog2(MAX_ENTRIES + 1);
  localparam int CW     = (CAP_W > POS_W) ? CAP_W : POS_W;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);

  logic              kind_r,      kind_nxt;
  logic [IDX_W-1:0]  left_r,      left_nxt;
  logic [DATA_W-1:0] delta_r,     delta_nxt;
  logic [POS_W-1:0]  walk_r,      walk_nxt;
  logic [DATA_W-1:0] acc_r,       acc_nxt;
  logic [DATA_W-1:0] hi_r,        hi_nxt;
  logic [DATA_W-1:0] out_data_r,  out_data_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              pend_r,      pend_nxt;
  logic [AW-1:0]     prev_addr_r, prev_addr_nxt;
  logic [AW-1:0]     clr_cnt_r,   clr_cnt_nxt;
  logic [IDX_W-1:0]  size_r,      size_nxt;

  logic [IDX_W-1:0]  f_left, f_right;
  logic [DATA_W-1:0] f_delta;
  logic [CW-1:0]     walk_ext, addr_full;
  logic [POS_W-1:0]  low_bit;
  logic              in_cap, in_size, nz, step_ok, rd_go;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              wr_en;
  logic [DATA_W-1:0] wr_data, ram_q;

  assign f_left  = in_tdata[IDX_W-1:0];
  assign f_right = in_tdata[2*IDX_W-1:IDX_W];
  assign f_delta = in_tdata[2*IDX_W+DATA_W-1:2*IDX_W];

  assign walk_ext  = CW'(walk_r);
  assign in_cap    = walk_ext <= MAX_C;
  assign in_size   = walk_ext <= CW'(size_r);
  assign nz        = walk_r != '0;
  // An add stops at the bound; a prefix walk runs to zero and skips positions
  // past the capacity, which contribute nothing.
  assign step_ok   = (kind_r == REQ_ADD) ? (nz && in_cap && in_size) : nz;
  assign rd_go     = cmd.step && step_ok && in_cap;
  assign addr_full = walk_ext - CW'(1);
  assign rd_addr   = addr_full[AW-1:0];
  assign low_bit   = walk_r & (~walk_r + POS_W'(1));

  // The write of an add step lands in the cycle after its read, while the next
  // position (always a different one) is being read.
  assign wr_en   = cmd.clear || (pend_r && (kind_r == REQ_ADD));
  assign wr_addr = cmd.clear ? clr_cnt_r : prev_addr_r;
  assign wr_data = cmd.clear ? '0 : ram_q + delta_r;

  fpa_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ENTRIES)
  ) u_tree (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_go),
    .rd_addr   (rd_addr),
    .rd_data_r (ram_q)
  );

  always_comb begin
    kind_nxt      = kind_r;
    left_nxt      = left_r;
    delta_nxt     = delta_r;
    walk_nxt      = walk_r;
    acc_nxt       = acc_r;
    hi_nxt        = hi_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    pend_nxt      = rd_go;
    prev_addr_nxt = rd_addr;
    clr_cnt_nxt   = cmd.clear ? clr_cnt_r + AW'(1) : clr_cnt_r;
    size_nxt      = cfg_valid ? cfg_data : size_r;

    if (cmd.load) begin
      kind_nxt  = in_tuser;
      left_nxt  = f_left;
      delta_nxt = f_delta;
      walk_nxt  = (in_tuser == REQ_SUM) ? {1'b0, f_right} : {1'b0, f_left};
      acc_nxt   = '0;
    end else if (cmd.lo_load) begin
      hi_nxt   = acc_r;
      acc_nxt  = '0;
      walk_nxt = (left_r == '0) ? '0 : {1'b0, left_r} - POS_W'(1);
    end else begin
      if (cmd.step && step_ok) begin
        walk_nxt = (kind_r == REQ_ADD) ? walk_r + low_bit : walk_r - low_bit;
      end
      if (pend_r && (kind_r == REQ_SUM)) begin
        acc_nxt = acc_r + ram_q;
      end
    end

    if (cmd.finish) begin
      out_data_nxt  = hi_r - acc_r;
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      clr_cnt_r   <= '0;
      size_r      <= SIZE_RESET;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      size_r      <= size_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    left_r      <= left_nxt;
    delta_r     <= delta_nxt;
    walk_r      <= walk_nxt;
    acc_r       <= acc_nxt;
    hi_r        <= hi_nxt;
    out_data_r  <= out_data_nxt;
    prev_addr_r <= prev_addr_nxt;
  end

  assign sts.clr_last = clr_cnt_r == AW'(MAX_ENTRIES - 1);
  assign sts.step_ok  = step_ok;
  assign sts.out_busy = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// File: rtl/fenwick_point_add_range_sum_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fenwick_point_add_range_sum_unit
// Binary indexed tree with point add and range sum over 32-bit wrapping counters.
// ----------------------------------------------------------------------------
// Input stream: in_tuser selects add (0) or range sum (1); in_tdata carries the
// left index, right index and delta. An add produces no output beat; a range
// sum produces one out_tdata beat with prefix(right) minus prefix(left-1).
// cfg_valid/cfg_data write the active size; it is taken in any cycle.
// After reset the tree memory is cleared one entry per cycle, all MAX_ENTRIES
// entries, and no input beat is accepted until the pass is done.
// Timing is set by the walk over the single tree memory, one position per
// cycle. An add walks upward over the positions it updates (at most 11). A
// range sum walks down from right over its set bits, then from left-1 over
// its set bits, and loads the difference in a finish step; its result appears in
// the output register and the next input beat is taken in the following cycle.
// Items are handled one at a time. A result waiting on a stalled receiver does
// not block acceptance; only a second result waits until the first is taken.
// ----------------------------------------------------------------------------
module fenwick_point_add_range_sum_unit
  import fpa_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Input beat.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // in_tuser: [0] req_type
  input  wire logic                   in_tuser,
  // in_tdata: [10:0] left_index, [21:11] right_index, [53:22] delta, [55:54] zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // Result beat.
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // out_tdata: [31:0] range_sum
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // Size register write.
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [IDX_W-1:0]       cfg_data
);

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready = 1'b1;

  fpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .sts       (sts),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  fpa_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTH
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear, cmd.load, cmd.step, cmd.lo_load, cmd.finish}))
    else $error("more than one datapath command at once");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(out_tvalid && !out_tready))
    else $error("result loaded over an untaken result");

  a_rose_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.finish))
    else $error("output beat without a finished query");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> !in_tready)
    else $error("input accepted during the clearing pass");
`endif

endmodule
`default_nettype wire
